FILE: rtl/hysteresis_table_interpolator_assert.svh
// Assertion macros shared by the block's checker.
`ifndef HYSTERESIS_TABLE_INTERPOLATOR_ASSERT_SVH
`define HYSTERESIS_TABLE_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define HTI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define HTI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/hti_pkg.sv
// Types and constants of the hysteresis table interpolator.
`default_nettype none
package hti_pkg;

  localparam int VALUE_BITS = 16;
  localparam int WORD_BITS  = 3 * VALUE_BITS;

  localparam logic [1:0] FN_LOAD   = 2'd0;
  localparam logic [1:0] FN_LOOKUP = 2'd1;
  localparam logic [1:0] FN_CHECK  = 2'd2;

  localparam logic [1:0] MODE_ASC  = 2'd0;
  localparam logic [1:0] MODE_DESC = 2'd1;
  localparam logic [1:0] MODE_HYST = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [1:0] REG_LENGTH = 2'd0;
  localparam logic [1:0] REG_MODE   = 2'd1;
  localparam logic [1:0] REG_TDESC  = 2'd2;

  localparam logic [4:0] LENGTH_RESET = 5'd16;
  localparam int         MIN_LENGTH   = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_LAST,
    PH_SEARCH,
    PH_SEG_LO,
    PH_SEG_HI
  } phase_e;

endpackage
`default_nettype wire

FILE: rtl/hti_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module hti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/hysteresis_table_interpolator.sv
// Breakpoint table interpolator with rise and fall curves (top level).
//
// Input stream: one beat per item; tuser carries the function (load, lookup,
// check), tdata the entry fields and the sample. Output stream: one beat per
// item; tdata is the result value, tuser the status and clamped flags.
// APB port: table_length, mode and target_descending at byte 0, 4, 8; a
// write to any of them clears the table's valid flag.
// The table sits in one RAM (index, rise, fall side by side), one read per
// cycle with a registered read; all work is serial around that port.
// Items are taken one at a time, tready is high only while idle.
// Steps: load, unknown function, a lookup with no valid table and a check
// with a bad table_length go straight to output; check reads each entry once;
// lookup reads and evaluates each probed entry (first, last, up to
// log2(table_length) search probes, two segment ends), then, unless it ends
// early, a multiply, a divide (one quotient bit a cycle) and the output step.
// The result sits in an output register; a new item is accepted while it
// waits. A finished result waits in its own state if the previous one has
// not been taken, and no further item is accepted then.
// Reset: registers as listed, table not valid; RAM contents undefined
// until loaded.
`default_nettype none
module hysteresis_table_interpolator
  import hti_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [3:0] entry_index, [19:4] index_point, [35:20] rise_value,
  // [51:36] fall_value, [67:52] sample, [71:68] zero
  input  wire logic [71:0] s_axis_tdata,
  // [1:0] func
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] result_value
  output logic [15:0]      m_axis_tdata,
  // [0] status, [1] clamped
  output logic [1:0]       m_axis_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int VB = VALUE_BITS;

  state_e st_q, st_d;
  phase_e ph_q, ph_d;

  logic [4:0] len_q;
  logic [1:0] mode_q;
  logic       tdesc_q;
  logic       valid_q, valid_d;
  logic [VB-1:0] prev_q, prev_d;

  logic [VB-1:0] x_q, x_d;
  logic          fall_q, fall_d;
  logic [CW-1:0] top_q, top_d, bot_q, bot_d, cur_q, cur_d, la_q, la_d;
  logic [VB-1:0] s0_q, s0_d, t0_q, t0_d, off_q, off_d, w_q, w_d, dt_q, dt_d;
  logic          dn_q, dn_d;
  logic [VB-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [4:0]    dcnt_q, dcnt_d;

  logic [CW-1:0] cnt_q, cnt_d, rid_q, rid_d;
  logic          rv_q, rv_d;
  logic          iok_q, iok_d, rok_q, rok_d, fok_q, fok_d;
  logic [VB-1:0] idx0_q, idx0_d;
  logic [WORD_BITS-1:0] last_q, last_d;

  logic [VB-1:0] rv_val_q, rv_val_d;
  logic          rs_q, rs_d, rc_q, rc_d;
  logic          mv_q, mv_d;
  logic [15:0]   md_q, md_d;
  logic [1:0]    mu_q, mu_d;

  logic                 s_acc, cfg_wr, out_free, desc, len_bad;
  logic [1:0]           in_func;
  logic [3:0]           in_entry;
  logic [VB-1:0]        in_sample;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, rdata;
  logic [VB-1:0]        r_idx, r_rise, r_fall, r_t;
  logic                 below, above, hit;
  logic [CW-1:0]        top_n, bot_n, cur_n, bot_init;
  logic [CW:0]          mid_sum;
  logic                 last_read, ok_i, ok_r, ok_f;
  logic [VB:0]          trial;
  logic                 eval_done, eval_mul;

  assign s_axis_tready = (st_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign in_func       = s_axis_tuser;
  assign in_entry      = s_axis_tdata[3:0];
  assign in_sample     = s_axis_tdata[67:52];
  assign cfg_wr        = psel & penable & pwrite;
  assign pready        = 1'b1;
  assign out_free      = ~mv_q | m_axis_tready;
  assign desc          = (mode_q == MODE_DESC);
  assign len_bad       = (int'(len_q) < MIN_LENGTH) || (int'(len_q) > TABLE_DEPTH);
  assign bot_init      = CW'(len_q - 5'd1);

  // RAM: one word per entry, index in the low field, then rise, then fall
  assign ram_we    = s_acc && (in_func == FN_LOAD) && (int'(in_entry) < TABLE_DEPTH);
  assign ram_waddr = AW'(in_entry);
  assign ram_wdata = {s_axis_tdata[51:36], s_axis_tdata[35:20], s_axis_tdata[19:4]};
  assign ram_raddr = (st_q == ST_CHECK) ? cnt_q[AW-1:0] : la_q[AW-1:0];

  hti_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  assign r_idx  = rdata[VB-1:0];
  assign r_rise = rdata[2*VB-1:VB];
  assign r_fall = rdata[3*VB-1:2*VB];
  assign r_t    = fall_q ? r_fall : r_rise;

  assign below = desc ? (x_q > r_idx) : (x_q < r_idx);
  assign above = desc ? (x_q < r_idx) : (x_q > r_idx);
  assign hit   = (x_q == r_idx);

  assign top_n   = above ? cur_q : top_q;
  assign bot_n   = above ? bot_q : cur_q;
  assign mid_sum = {1'b0, top_n} + {1'b0, bot_n};
  assign cur_n   = mid_sum[CW:1];

  // check sweep: compare the entry just read against the one before it
  assign last_read = rv_q && (rid_q == bot_init);
  assign ok_i = desc ? (last_q[VB-1:0] >= r_idx) : (last_q[VB-1:0] <= r_idx);
  assign ok_r = ((mode_q != MODE_HYST) && tdesc_q) ? (last_q[2*VB-1:VB] >= r_rise)
                                                   : (last_q[2*VB-1:VB] <= r_rise);
  assign ok_f = (mode_q != MODE_HYST) || (last_q[3*VB-1:2*VB] >= r_fall);

  assign trial = {rem_q, quo_q[VB-1]};

  always_comb begin
    eval_done = 1'b0;
    eval_mul  = 1'b0;
    unique case (ph_q)
      PH_FIRST:  eval_done = below;
      PH_LAST:   eval_done = above;
      PH_SEARCH: eval_done = hit;
      PH_SEG_LO: eval_done = 1'b0;
      PH_SEG_HI: begin
        eval_done = (r_idx == s0_q);
        eval_mul  = (r_idx != s0_q);
      end
      default: eval_done = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (s_acc) begin
          if (in_func == FN_LOOKUP && valid_q) begin
            st_d = ST_READ;
          end else if (in_func == FN_CHECK && !len_bad) begin
            st_d = ST_CHECK;
          end else begin
            st_d = ST_DONE;
          end
        end
      end
      ST_CHECK: if (last_read) st_d = ST_DONE;
      ST_READ:  st_d = ST_EVAL;
      ST_EVAL: begin
        if (eval_done) begin
          st_d = ST_DONE;
        end else if (eval_mul) begin
          st_d = ST_MUL;
        end else begin
          st_d = ST_READ;
        end
      end
      ST_MUL:  st_d = ST_DIV;
      ST_DIV:  if (dcnt_q == 5'(VB - 1)) st_d = ST_DONE;
      ST_DONE: if (out_free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    ph_d = ph_q;   valid_d = valid_q; prev_d = prev_q;
    x_d = x_q;     fall_d = fall_q;
    top_d = top_q; bot_d = bot_q; cur_d = cur_q; la_d = la_q;
    s0_d = s0_q;   t0_d = t0_q; off_d = off_q; w_d = w_q; dt_d = dt_q; dn_d = dn_q;
    rem_d = rem_q; quo_d = quo_q; dcnt_d = dcnt_q;
    cnt_d = cnt_q; rid_d = rid_q; rv_d = 1'b0;
    iok_d = iok_q; rok_d = rok_q; fok_d = fok_q; idx0_d = idx0_q; last_d = last_q;
    rv_val_d = rv_val_q; rs_d = rs_q; rc_d = rc_q;
    mv_d = mv_q & ~m_axis_tready; md_d = md_q; mu_d = mu_q;

    // of the APB writes, only one to a mapped register invalidates the table
    if (cfg_wr && ((paddr[3:2] == REG_LENGTH) || (paddr[3:2] == REG_MODE) ||
                   (paddr[3:2] == REG_TDESC))) begin
      valid_d = 1'b0;
    end

    unique case (st_q)
      ST_IDLE: begin
        if (s_acc) begin
          rv_val_d = '0;
          rs_d     = 1'b0;
          rc_d     = 1'b0;
          unique case (in_func)
            FN_LOAD: valid_d = 1'b0;
            FN_LOOKUP: begin
              if (valid_q) begin
                x_d    = in_sample;
                fall_d = (mode_q == MODE_HYST) && (prev_q > in_sample);
                prev_d = in_sample;
                top_d  = '0;
                bot_d  = bot_init;
                cur_d  = bot_init >> 1;
                la_d   = '0;
                ph_d   = PH_FIRST;
              end else begin
                rs_d = 1'b1;
              end
            end
            FN_CHECK: begin
              valid_d = 1'b0;
              rs_d    = len_bad;
              cnt_d   = '0;
              iok_d   = 1'b1;
              rok_d   = 1'b1;
              fok_d   = 1'b1;
            end
            default: rs_d = 1'b1;
          endcase
        end
      end
      ST_CHECK: begin
        if (int'(cnt_q) < int'(len_q)) begin
          rv_d  = 1'b1;
          rid_d = cnt_q;
          cnt_d = cnt_q + 1'b1;
        end
        if (rv_q) begin
          last_d = rdata;
          if (rid_q == '0) begin
            idx0_d = r_idx;
          end else begin
            iok_d = iok_q & ok_i;
            rok_d = rok_q & ok_r;
            fok_d = fok_q & ok_f;
          end
          if (last_read) begin
            if (iok_q & ok_i) prev_d = idx0_q;
            valid_d = iok_q & ok_i & rok_q & ok_r & fok_q & ok_f;
            rs_d    = ~(iok_q & ok_i & rok_q & ok_r & fok_q & ok_f);
          end
        end
      end
      ST_READ: ;
      ST_EVAL: begin
        unique case (ph_q)
          PH_FIRST: begin
            rv_val_d = r_t;
            rc_d     = below;
            la_d     = bot_q;
            ph_d     = PH_LAST;
          end
          PH_LAST: begin
            rv_val_d = r_t;
            rc_d     = above;
            la_d     = cur_q;
            ph_d     = (cur_q > top_q) ? PH_SEARCH : PH_SEG_LO;
          end
          PH_SEARCH: begin
            rv_val_d = r_t;
            top_d    = top_n;
            bot_d    = bot_n;
            cur_d    = cur_n;
            la_d     = cur_n;
            ph_d     = (cur_n > top_n) ? PH_SEARCH : PH_SEG_LO;
          end
          PH_SEG_LO: begin
            s0_d = r_idx;
            t0_d = r_t;
            la_d = cur_q + 1'b1;
            ph_d = PH_SEG_HI;
          end
          PH_SEG_HI: begin
            rv_val_d = t0_q;
            off_d    = desc ? (s0_q - x_q) : (x_q - s0_q);
            w_d      = desc ? (s0_q - r_idx) : (r_idx - s0_q);
            dn_d     = (r_t < t0_q);
            dt_d     = (r_t < t0_q) ? (t0_q - r_t) : (r_t - t0_q);
          end
          default: ;
        endcase
      end
      ST_MUL: begin
        // off <= w, so the high half is already below the divisor
        {rem_d, quo_d} = off_q * dt_q;
        dcnt_d         = '0;
      end
      ST_DIV: begin
        dcnt_d = dcnt_q + 5'd1;
        if (trial >= {1'b0, w_q}) begin
          rem_d = VB'(trial - {1'b0, w_q});
          quo_d = {quo_q[VB-2:0], 1'b1};
        end else begin
          rem_d = trial[VB-1:0];
          quo_d = {quo_q[VB-2:0], 1'b0};
        end
        if (dcnt_q == 5'(VB - 1)) begin
          // falling segment rounds the magnitude up so the result floors
          if (dn_q) begin
            rv_val_d = t0_q - quo_d - VB'(rem_d != '0);
          end else begin
            rv_val_d = t0_q + quo_d;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          mv_d = 1'b1;
          md_d = 16'(rv_val_q);
          mu_d = {rc_q, rs_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      ph_q    <= PH_FIRST;
      valid_q <= 1'b0;
      prev_q  <= '0;
      rv_q    <= 1'b0;
      mv_q    <= 1'b0;
      len_q   <= LENGTH_RESET;
      mode_q  <= MODE_ASC;
      tdesc_q <= 1'b0;
      dcnt_q  <= '0;
      cnt_q   <= '0;
    end else begin
      st_q    <= st_d;
      ph_q    <= ph_d;
      valid_q <= valid_d;
      prev_q  <= prev_d;
      rv_q    <= rv_d;
      mv_q    <= mv_d;
      dcnt_q  <= dcnt_d;
      cnt_q   <= cnt_d;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_LENGTH: len_q   <= pwdata[4:0];
          REG_MODE:   mode_q  <= (pwdata[1:0] == MODE_NONE) ? MODE_ASC : pwdata[1:0];
          REG_TDESC:  tdesc_q <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;     fall_q <= fall_d;
    top_q <= top_d; bot_q <= bot_d; cur_q <= cur_d; la_q <= la_d;
    s0_q <= s0_d;   t0_q <= t0_d; off_q <= off_d; w_q <= w_d; dt_q <= dt_d; dn_q <= dn_d;
    rem_q <= rem_d; quo_q <= quo_d;
    rid_q <= rid_d;
    iok_q <= iok_d; rok_q <= rok_d; fok_q <= fok_d; idx0_q <= idx0_d; last_q <= last_d;
    rv_val_q <= rv_val_d; rs_q <= rs_d; rc_q <= rc_d;
    md_q <= md_d;   mu_q <= mu_d;
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LENGTH: prdata = {27'd0, len_q};
      REG_MODE:   prdata = {30'd0, mode_q};
      REG_TDESC:  prdata = {31'd0, tdesc_q};
      default:    prdata = '0;
    endcase
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;
  assign m_axis_tuser  = mu_q;

endmodule
`default_nettype wire

FILE: rtl/hti_checker.sv
// Port-level checker for the interpolator, bound to the top level.
`default_nettype none
`include "hysteresis_table_interpolator_assert.svh"
module hti_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        pready
);

  `HTI_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output beat changed while stalled")
  `HTI_ASSERT_NOW(a_err_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 16'd0, "error beat carries a nonzero value")
  `HTI_ASSERT_NOW(a_clamp_ok, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0], "clamped beat flagged as error")
  `HTI_ASSERT_NOW(a_pready, 1'b1, pready, "pready dropped")

endmodule

bind hysteresis_table_interpolator hti_checker u_hti_checker (.*);
`default_nettype wire
